@@ hw/rtl/pimc_pkg.sv @@
// Shared constants, register codes and types for the perspective inverse mapper.
// Used by pimc_divide and perspective_inverse_map_coords.
package pimc_pkg;

	localparam int INDEX_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int COL_W          = 12;
	localparam int COEF_W         = 32;
	localparam int CFG_W          = 64;
	localparam int CFG_IDX_W      = 4;
	localparam int LIM_W          = 16;
	// low part of a plane coordinate taken by the split multipliers
	localparam int LO_W           = 25;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_A      = 4'd0,
		REG_COEF_B      = 4'd1,
		REG_COEF_C      = 4'd2,
		REG_COEF_D      = 4'd3,
		REG_COEF_LAST   = 4'd4,
		REG_PLANE_ORG   = 4'd5,
		REG_PLANE_STEP  = 4'd6,
		REG_SOURCE_SIZE = 4'd7
	} cfg_reg_t;

	typedef struct packed {
		logic neg;
		logic num_zero;
		logic den_zero;
	} axis_flags_t;

	// quotient bits kept: enough for the 32-bit saturation and for the bound test
	function automatic int quo_bits(input int frac);
		return (frac + 17 > 33) ? frac + 17 : 33;
	endfunction

endpackage

@@ hw/rtl/pimc_divide.sv @@
// Two-lane pipelined restoring divider with saturation and bound test.
// Depends on pimc_pkg.
module pimc_divide import pimc_pkg::*; #(
	parameter int INDEX_BITS = INDEX_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     en,
	input  logic                                     valid_in,
	input  logic [INDEX_BITS+67+FRAC_BITS-1:0]       num [2],
	input  logic [INDEX_BITS+67-1:0]                 den,
	input  axis_flags_t                              flags [2],
	input  logic [LIM_W-1:0]                         lim [2],
	output logic                                     valid_out,
	output logic [COEF_W-1:0]                        coord [2],
	output logic                                     inside_flag
);

	localparam int SW  = INDEX_BITS + 67;
	localparam int QW  = quo_bits(FRAC_BITS);
	localparam int CW  = SW + QW + 1;
	localparam logic [COEF_W-1:0] SAT_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic [COEF_W-1:0] SAT_MIN = {1'b1, {(COEF_W-1){1'b0}}};

	logic              v_s   [0:QW];
	logic [CW-1:0]     rem_s [0:QW-1][2];
	logic [QW-1:0]     quo_s [0:QW][2];
	logic [SW-1:0]     den_s [0:QW-1];
	axis_flags_t       flg_s [0:QW][2];
	logic              ovf_s [0:QW][2];
	logic [LIM_W-1:0]  lim_s [0:QW][2];

	logic              vout_q;
	logic [COEF_W-1:0] coord_q [2];
	logic              inside_q;
	logic              in_lane [2];

	// entry stage: quotient overflow test, remainder loaded with the numerator
	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= den;
			for (int j = 0; j < 2; j++) begin
				rem_s[0][j] <= CW'(num[j]);
				quo_s[0][j] <= '0;
				flg_s[0][j] <= flags[j];
				lim_s[0][j] <= lim[j];
				ovf_s[0][j] <= CW'(num[j]) >= (CW'(den) << QW);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QW; k++) v_s[k] <= 1'b0;
			vout_q <= 1'b0;
		end else if (en) begin
			v_s[0] <= valid_in;
			for (int k = 1; k <= QW; k++) v_s[k] <= v_s[k-1];
			vout_q <= v_s[QW];
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < QW; k++) begin : g_step
		localparam int SH = QW - 1 - k;
		for (genvar j = 0; j < 2; j++) begin : g_lane
			logic [CW-1:0] dsh;
			logic          ge;
			always_comb begin
				dsh = CW'(den_s[k]) << SH;
				ge  = rem_s[k][j] >= dsh;
			end
			always_ff @(posedge clk) begin
				if (en) begin
					quo_s[k+1][j] <= quo_s[k][j] | (QW'(ge) << SH);
					flg_s[k+1][j] <= flg_s[k][j];
					lim_s[k+1][j] <= lim_s[k][j];
					ovf_s[k+1][j] <= ovf_s[k][j];
				end
			end
			// last stage only needs the quotient bit
			if (k < QW - 1) begin : g_rem
				always_ff @(posedge clk) begin
					if (en) rem_s[k+1][j] <= ge ? rem_s[k][j] - dsh : rem_s[k][j];
				end
			end
		end
		if (k < QW - 1) begin : g_den
			always_ff @(posedge clk) begin
				if (en) den_s[k+1] <= den_s[k];
			end
		end
	end

	for (genvar j = 0; j < 2; j++) begin : g_out
		logic [QW-1:0]     q;
		logic [QW-1:0]     lim_sh;
		axis_flags_t       f;
		logic              sat_pos;
		logic              sat_neg;
		logic [COEF_W-1:0] c;
		always_comb begin
			q       = quo_s[QW][j];
			f       = flg_s[QW][j];
			lim_sh  = QW'({lim_s[QW][j], {FRAC_BITS{1'b0}}});
			sat_pos = ovf_s[QW][j] || (q > QW'(SAT_MAX));
			sat_neg = ovf_s[QW][j] || (q > QW'(SAT_MIN));
			if (f.den_zero) begin
				c = f.num_zero ? '0 : (f.neg ? SAT_MIN : SAT_MAX);
			end else if (f.neg) begin
				c = sat_neg ? SAT_MIN : COEF_W'(-q[COEF_W-1:0]);
			end else begin
				c = sat_pos ? SAT_MAX : q[COEF_W-1:0];
			end
			// exact ratio below the bound iff the floored quotient is below it
			in_lane[j] = !f.den_zero && !f.neg && !f.num_zero && !ovf_s[QW][j]
				&& (q < lim_sh);
		end
		always_ff @(posedge clk) begin
			if (en) coord_q[j] <= c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) inside_q <= in_lane[0] & in_lane[1];
	end

	assign valid_out   = vout_q;
	assign coord[0]    = coord_q[0];
	assign coord[1]    = coord_q[1];
	assign inside_flag = inside_q;

endmodule

@@ hw/rtl/perspective_inverse_map_coords.sv @@
// Perspective inverse mapper: output pixel index to source coordinate.
// Depends on pimc_pkg and pimc_divide.
//
// Input channel: in_valid/in_stall with out_col, out_row (one output pixel).
// Output channel: out_valid/out_stall with src_x, src_y (signed Q16.16,
// saturated) and inside_res.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high, unknown indexes are dropped. Write only while idle.
// One word in per clock, one word out per clock, while out_stall does not
// hold a waiting result. Registers in order: plane point, split products,
// product merge, dot sums, sign fixup, overflow check, the quotient-bit
// stages of the restoring divider (quotient quo_bits(FRAC_BITS) bits wide,
// 33 at Q16.16), then the output register. The divider chain sets the depth.
// The pipeline advances as a whole; when out_stall holds a waiting result,
// every stage holds and in_stall rises, nothing is lost or repeated.
// Reset clears all valid bits and loads the registers with an identity
// w row (coef_last = 1.0) and zeros elsewhere.
module perspective_inverse_map_coords import pimc_pkg::*; #(
	parameter int INDEX_BITS = INDEX_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COL_W-1:0]      out_col,
	input  logic [COL_W-1:0]      out_row,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [31:0]    src_x,
	output logic signed [31:0]    src_y,
	output logic                  inside_res,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	localparam int PW = COEF_W + INDEX_BITS + 1;
	localparam int HW = PW - LO_W;
	localparam int MW = COEF_W + PW;
	localparam int SW = INDEX_BITS + 67;
	localparam int NW = SW + FRAC_BITS;
	localparam int PLW = COEF_W + LO_W + 1;
	localparam int PHW = COEF_W + HW;

	logic [CFG_W-1:0]  coef_a_q, coef_b_q, coef_c_q, coef_d_q;
	logic [COEF_W-1:0] coef_last_q;
	logic [CFG_W-1:0]  org_q, step_q;
	logic [31:0]       size_q;

	logic en;
	assign en        = !out_valid || !out_stall;
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q    <= '0;
			coef_b_q    <= '0;
			coef_c_q    <= '0;
			coef_d_q    <= '0;
			coef_last_q <= COEF_W'(1) << FRAC_BITS;
			org_q       <= '0;
			step_q      <= '0;
			size_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_COEF_A:      coef_a_q    <= cfg_data;
				REG_COEF_B:      coef_b_q    <= cfg_data;
				REG_COEF_C:      coef_c_q    <= cfg_data;
				REG_COEF_D:      coef_d_q    <= cfg_data;
				REG_COEF_LAST:   coef_last_q <= cfg_data[31:0];
				REG_PLANE_ORG:   org_q       <= cfg_data;
				REG_PLANE_STEP:  step_q      <= cfg_data;
				REG_SOURCE_SIZE: size_q      <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	logic signed [COEF_W-1:0] m [6];
	assign m[0] = $signed(coef_a_q[31:0]);
	assign m[1] = $signed(coef_a_q[63:32]);
	assign m[2] = $signed(coef_b_q[63:32]);
	assign m[3] = $signed(coef_c_q[31:0]);
	assign m[4] = $signed(coef_d_q[31:0]);
	assign m[5] = $signed(coef_d_q[63:32]);

	// stage 1: plane point
	logic [INDEX_BITS-1:0] col, row;
	logic signed [PW-1:0]  px_c, py_c, px_s1, py_s1;
	logic                  v_s1, v_s2, v_s3, v_s4, v_s5;
	assign col  = INDEX_BITS'(out_col);
	assign row  = INDEX_BITS'(out_row);
	assign px_c = PW'($signed(org_q[31:0]))
		+ PW'($signed({1'b0, col})) * PW'($signed(step_q[31:0]));
	assign py_c = PW'($signed(org_q[63:32]))
		+ PW'($signed({1'b0, row})) * PW'($signed(step_q[63:32]));

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= px_c;
			py_s1 <= py_c;
		end
	end

	// stage 2: each 32 x PW product split into a low and a high partial
	logic signed [PLW-1:0] pl_s2 [6];
	logic signed [PHW-1:0] ph_s2 [6];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 6; k++) begin
				pl_s2[k] <= m[k] * $signed({1'b0,
					(k % 2 == 0) ? px_s1[LO_W-1:0] : py_s1[LO_W-1:0]});
				ph_s2[k] <= m[k] * ((k % 2 == 0) ? $signed(px_s1[PW-1:LO_W])
					: $signed(py_s1[PW-1:LO_W]));
			end
		end
	end

	// stage 3: merge partials
	logic signed [MW-1:0] prod_s3 [6];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 6; k++)
				prod_s3[k] <= (MW'(ph_s2[k]) <<< LO_W) + MW'(pl_s2[k]);
		end
	end

	// stage 4: dot products X, Y, W
	logic signed [SW-1:0] xs_s4, ys_s4, ws_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			xs_s4 <= SW'(prod_s3[0]) + SW'(prod_s3[1])
				+ (SW'($signed(coef_b_q[31:0])) <<< FRAC_BITS);
			ys_s4 <= SW'(prod_s3[2]) + SW'(prod_s3[3])
				+ (SW'($signed(coef_c_q[63:32])) <<< FRAC_BITS);
			ws_s4 <= SW'(prod_s3[4]) + SW'(prod_s3[5])
				+ (SW'($signed(coef_last_q)) <<< FRAC_BITS);
		end
	end

	// stage 5: make the divisor positive, split numerators into sign and magnitude
	logic                 wneg;
	logic signed [SW-1:0] nx, ny;
	logic [SW-1:0]        dmag;
	logic [NW-1:0]        num_s5 [2];
	logic [SW-1:0]        den_s5;
	axis_flags_t          flg_s5 [2];
	assign wneg = ws_s4[SW-1];
	assign nx   = wneg ? -xs_s4 : xs_s4;
	assign ny   = wneg ? -ys_s4 : ys_s4;
	assign dmag = wneg ? SW'(-ws_s4) : SW'(ws_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			den_s5    <= dmag;
			num_s5[0] <= {(nx[SW-1] ? SW'(-nx) : SW'(nx)), {FRAC_BITS{1'b0}}};
			num_s5[1] <= {(ny[SW-1] ? SW'(-ny) : SW'(ny)), {FRAC_BITS{1'b0}}};
			flg_s5[0] <= '{neg: nx[SW-1], num_zero: (xs_s4 == '0),
				den_zero: (ws_s4 == '0)};
			flg_s5[1] <= '{neg: ny[SW-1], num_zero: (ys_s4 == '0),
				den_zero: (ws_s4 == '0)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	logic [LIM_W-1:0]  lim [2];
	logic [COEF_W-1:0] coord [2];
	assign lim[0] = size_q[15:0];
	assign lim[1] = size_q[31:16];

	pimc_divide #(
		.INDEX_BITS (INDEX_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.valid_in    (v_s5),
		.num         (num_s5),
		.den         (den_s5),
		.flags       (flg_s5),
		.lim         (lim),
		.valid_out   (out_valid),
		.coord       (coord),
		.inside_flag (inside_res)
	);

	assign src_x = $signed(coord[0]);
	assign src_y = $signed(coord[1]);

	a_inside_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && inside_res |-> !src_x[31] && !src_y[31])
		else $error("inside result with negative coordinate");

	a_inside_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && inside_res |-> (size_q[15:0] != '0) && (size_q[31:16] != '0))
		else $error("inside result with empty source");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && out_valid && out_stall |=> v_s5)
		else $error("pipeline word dropped under stall");

endmodule

@@ verif/tb.sv @@
// Testbench for perspective_inverse_map_coords: directed table, then random pixels.
// Depends on pimc_pkg and the mapper RTL; expected words: table rows or a local predictor.
module tb;
	import pimc_pkg::*;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [COL_W-1:0] out_col, out_row;
	logic signed [31:0] src_x, src_y;
	logic inside_res;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	perspective_inverse_map_coords u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .out_col(out_col), .out_row(out_row),
		.out_valid(out_valid), .out_stall(out_stall),
		.src_x(src_x), .src_y(src_y), .inside_res(inside_res),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	localparam int FB = FRAC_BITS_DEF;
	localparam int DRAIN = 60;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic        in;
	} coord_t;

	typedef struct {
		logic [11:0] col;
		logic [11:0] row;
		logic        known;
		coord_t      want;
	} pix_t;

	logic [63:0] regs[8];
	coord_t coord_q[$];
	int n_bad, n_seen, n_sent;
	int rx_gap;
	bit rx_idle_on, hold_rx;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] sat_axis(logic signed [127:0] num,
		logic signed [127:0] den);
		logic signed [127:0] q;
		if (den == 0)
			return (num == 0) ? 32'h0 : (num < 0 ? 32'h8000_0000 : 32'h7fff_ffff);
		q = (num <<< FB) / den;
		if (q > 128'sh7fff_ffff) return 32'h7fff_ffff;
		if (q < -128'sh8000_0000) return 32'h8000_0000;
		return q[31:0];
	endfunction

	function automatic bit axis_in(logic signed [127:0] num, logic signed [127:0] den,
		logic [15:0] lim);
		if (den == 0) return 0;
		if (den < 0) begin
			num = -num;
			den = -den;
		end
		if (num <= 0) return 0;
		return num < den * $signed({112'b0, lim});
	endfunction

	function automatic coord_t map_pixel(logic [11:0] col, logic [11:0] row);
		logic signed [127:0] px, py, xs, ys, ws;
		coord_t r;
		px = $signed(regs[REG_PLANE_ORG][31:0]) + $signed({1'b0, col})
			* $signed(regs[REG_PLANE_STEP][31:0]);
		py = $signed(regs[REG_PLANE_ORG][63:32]) + $signed({1'b0, row})
			* $signed(regs[REG_PLANE_STEP][63:32]);
		xs = $signed(regs[REG_COEF_A][31:0]) * px + $signed(regs[REG_COEF_A][63:32]) * py
			+ ($signed(regs[REG_COEF_B][31:0]) <<< FB);
		ys = $signed(regs[REG_COEF_B][63:32]) * px + $signed(regs[REG_COEF_C][31:0]) * py
			+ ($signed(regs[REG_COEF_C][63:32]) <<< FB);
		ws = $signed(regs[REG_COEF_D][31:0]) * px + $signed(regs[REG_COEF_D][63:32]) * py
			+ ($signed(regs[REG_COEF_LAST][31:0]) <<< FB);
		r.x = sat_axis(xs, ws);
		r.y = sat_axis(ys, ws);
		r.in = axis_in(xs, ws, regs[REG_SOURCE_SIZE][15:0])
			&& axis_in(ys, ws, regs[REG_SOURCE_SIZE][31:16]);
		return r;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx < 8) regs[idx] = (idx == REG_COEF_LAST || idx == REG_SOURCE_SIZE)
			? {32'b0, val[31:0]} : val;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// called at a falling edge; stops the sender and lets the pipe drain
	task automatic wait_idle();
		int guard;
		guard = 0;
		in_valid <= 0;
		while (coord_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN) @(posedge clk);
	endtask

	// send one pixel; sender gaps only when gaps is set
	task automatic send_pixel(logic [11:0] col, logic [11:0] row, bit gaps,
		bit known, coord_t want);
		coord_t e;
		if (gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_valid <= 1;
		out_col <= col;
		out_row <= row;
		do @(posedge clk); while (in_stall);
		e = map_pixel(col, row);
		if (known && e != want)
			$display("table row (%0d,%0d) disagrees with predictor", col, row);
		if (!known) want = e;
		coord_q = {coord_q, want};
		n_sent++;
		@(negedge clk);
	endtask

	task automatic random_cfg(bit extreme);
		logic [63:0] v;
		for (int i = 0; i < 8; i++) begin
			case ($urandom_range(0, extreme ? 2 : 5))
				0: v = 64'hffff_ffff_ffff_ffff;
				1: v = 64'h8000_0000_7fff_ffff;
				2: v = {$urandom, $urandom};
				default: v = {32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536),
					32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536)};
			endcase
			if (i == REG_COEF_LAST && $urandom_range(0, 3) == 0) v = 0;
			if (i == REG_SOURCE_SIZE && !extreme) v = {32'b0,
				16'($urandom_range(1, 4000)), 16'($urandom_range(1, 4000))};
			write_reg(i[CFG_IDX_W-1:0], v);
		end
		write_reg(4'd9, {$urandom, $urandom});
	endtask

	// receiver side: random stall bursts, or a long hold
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 0;
			rx_gap <= 0;
		end else if (hold_rx) begin
			out_stall <= 1;
		end else if (rx_gap > 0) begin
			out_stall <= 1;
			rx_gap <= rx_gap - 1;
		end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
			out_stall <= 1;
			rx_gap <= $urandom_range(0, 13);
		end else begin
			out_stall <= 0;
		end
	end

	always @(posedge clk) begin
		coord_t e, g;
		if (arst_n && out_valid && !out_stall) begin
			n_seen++;
			g.x = src_x;
			g.y = src_y;
			g.in = inside_res;
			if (coord_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10) $display("unexpected word x=%h y=%h in=%b", g.x, g.y, g.in);
			end else begin
				e = coord_q.pop_front();
				if (e != g) begin
					n_bad++;
					if (n_bad <= 10)
						$display("mismatch: want x=%h y=%h in=%b got x=%h y=%h in=%b",
							e.x, e.y, e.in, g.x, g.y, g.in);
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("** perspective_inverse_map_coords: FAILED **");
		$finish;
	end

	initial begin
		// directed: reset state maps to (0,0) with w=1, nothing inside (size 0)
		pix_t tbl[2];
		coord_t z, sx;
		int phase;
		bit ok;
		z = '{32'h0, 32'h0, 1'b0};
		arst_n = 0; in_valid = 0; out_col = 0; out_row = 0;
		cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		n_bad = 0; n_seen = 0; n_sent = 0;
		rx_idle_on = 0; hold_rx = 0;
		for (int i = 0; i < 8; i++) regs[i] = 0;
		regs[REG_COEF_LAST] = 64'h1_0000;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1;

		tbl[0] = '{12'd0, 12'd0, 1, z};
		tbl[1] = '{12'hfff, 12'hfff, 1, z};
		foreach (tbl[i]) send_pixel(tbl[i].col, tbl[i].row, 0, tbl[i].known, tbl[i].want);
		wait_idle();

		// identity map, unit steps, 100x50 source: edges and interior
		write_reg(REG_COEF_A, 64'h0000_0000_0001_0000);
		write_reg(REG_COEF_C, 64'h0000_0000_0001_0000);
		write_reg(REG_PLANE_STEP, 64'h0001_0000_0001_0000);
		write_reg(REG_SOURCE_SIZE, {32'b0, 16'd50, 16'd100});
		send_pixel(0, 10, 0, 1, '{32'h0, 32'h000a_0000, 1'b0});
		send_pixel(5, 7, 0, 1, '{32'h0005_0000, 32'h0007_0000, 1'b1});
		send_pixel(100, 7, 0, 1, '{32'h0064_0000, 32'h0007_0000, 1'b0});
		send_pixel(99, 49, 0, 1, '{32'h0063_0000, 32'h0031_0000, 1'b1});
		send_pixel(12'hfff, 12'hfff, 0, 1, '{32'h0fff_0000, 32'h0fff_0000, 1'b0});
		wait_idle();
		// w of zero: saturation by sign of numerator
		write_reg(REG_COEF_LAST, 64'h0);
		write_reg(REG_PLANE_ORG, {32'hffff_0000, 32'h0});
		sx = '{32'h7fff_ffff, 32'h8000_0000, 1'b0};
		send_pixel(3, 0, 0, 1, sx);
		send_pixel(0, 1, 0, 1, '{32'h0, 32'h0, 1'b0});
		wait_idle();
		// huge quotient and negative w
		write_reg(REG_COEF_LAST, 64'h0000_0000_0000_0001);
		write_reg(REG_COEF_D, 64'h0);
		write_reg(REG_PLANE_ORG, 64'h0);
		send_pixel(4000, 4000, 0, 1, '{32'h7fff_ffff, 32'h7fff_ffff, 1'b0});
		wait_idle();
		write_reg(REG_COEF_LAST, 64'h0000_0000_ffff_0000);
		send_pixel(5, 7, 0, 1, '{32'hfffb_0000, 32'hfff9_0000, 1'b0});
		send_pixel(12'h800, 12'h001, 0, 0, z);
		send_pixel(12'h7ff, 12'h555, 0, 0, z);
		send_pixel(12'haaa, 12'h400, 0, 0, z);
		wait_idle();

		// random phases, pixels at random positions, most within 0..300 on each axis
		rx_idle_on = 1;
		for (phase = 0; phase < 8; phase++) begin
			random_cfg(phase == 1 || phase == 5);
			if (phase == 2) fork
				begin
					hold_rx = 1;
					repeat (300) @(posedge clk);
					hold_rx = 0;
				end
			join_none
			if (phase == 7) rx_idle_on = 0;
			for (int k = 0; k < 90; k++) begin
				logic [11:0] c, r;
				ok = $urandom_range(0, 3) != 0;
				c = ok ? 12'($urandom_range(0, 300)) : 12'($urandom);
				r = ok ? 12'($urandom_range(0, 300)) : 12'($urandom);
				send_pixel(c, r, phase != 7, 0, z);
			end
			wait_idle();
		end

		$display("ran %0d pixels over 8 random register sets, %0d words checked",
			n_sent, n_seen);
		$display("saturation, zero w, bounds and a long output hold were included");
		if (n_bad == 0 && coord_q.size() == 0)
			$display("** perspective_inverse_map_coords: PASSED **");
		else
			$display("** perspective_inverse_map_coords: FAILED **");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/pimc_pkg.sv
hw/rtl/pimc_divide.sv
hw/rtl/perspective_inverse_map_coords.sv
verif/tb.sv
